// ===== rtl/isa_pkg.sv =====
// Shared types, constants and disk geometry helpers for the sector allocator.
// Used by isa_fmap, isa_glist and interleaved_sector_allocator; no dependencies.
package isa_pkg;

    localparam int MAX_TRACKS_DEF = 42;
    localparam int MAX_COUNT_DEF  = 64;

    localparam int TW   = 6;   // track field width
    localparam int SW   = 5;   // sector field width
    localparam int BW   = 10;  // block number width
    localparam int CW   = 7;   // count field width
    localparam int ROWW = 21;  // one free-map row, the most sectors on a track
    localparam int GW   = TW + SW;

    localparam logic [TW-1:0] DIR_TRACK = 6'd18;
    localparam logic [TW-1:0] SKIP_FROM = 6'd17;
    localparam logic [TW-1:0] SKIP_TO   = 6'd19;

    localparam logic [1:0] CFG_START_TRACK  = 2'd0;
    localparam logic [1:0] CFG_START_SECTOR = 2'd1;
    localparam logic [1:0] CFG_NUM_TRACKS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_QDONE,
        S_WRD,
        S_WLD,
        S_WCHK,
        S_CRG,
        S_CRM,
        S_CWR
    } state_t;

    typedef struct packed {
        logic [TW-1:0] trk;
        logic [SW-1:0] sec;
    } pos_t;

    function automatic logic [SW-1:0] secs_on(input logic [TW-1:0] t);
        logic [SW-1:0] n;
        if (t <= 6'd17)      n = 5'd21;
        else if (t <= 6'd24) n = 5'd19;
        else if (t <= 6'd30) n = 5'd18;
        else                 n = 5'd17;
        return n;
    endfunction

    function automatic logic [BW-1:0] base_of(input logic [TW-1:0] t);
        logic [BW-1:0] tt;
        logic [BW-1:0] b;
        tt = {4'b0, t};
        if (t <= 6'd17)      b = (tt - 10'd1) * 10'd21;
        else if (t <= 6'd24) b = 10'd357 + (tt - 10'd18) * 10'd19;
        else if (t <= 6'd30) b = 10'd490 + (tt - 10'd25) * 10'd18;
        else                 b = 10'd598 + (tt - 10'd31) * 10'd17;
        return b;
    endfunction

    function automatic logic [ROWW-1:0] row_mask(input logic [TW-1:0] t);
        logic [ROWW:0] m;
        m = ((ROWW+1)'(1) << secs_on(t)) - (ROWW+1)'(1);
        return m[ROWW-1:0];
    endfunction

    function automatic logic pos_valid(input logic [TW-1:0] t, input logic [SW-1:0] s,
                                       input logic [TW-1:0] eff);
        return (t >= 6'd1) && (t <= eff) && (s < secs_on(t));
    endfunction

    // One interleave step from a valid position.
    function automatic pos_t step_pos(input logic [TW-1:0] t, input logic [SW-1:0] s,
                                      input logic [TW-1:0] eff);
        logic [SW:0]   ns;
        logic [SW-1:0] n;
        pos_t          p;
        n = secs_on(t);
        p.trk = t;
        if (t == DIR_TRACK) begin
            ns = {1'b0, s} + 6'd3;
            if (ns >= 6'd19) ns = ns - 6'd19;
            p.sec = ns[SW-1:0];
            if (ns == '0) p.trk = '0;
        end else begin
            if (n == 5'd18 && s == 5'd8)      ns = 6'd1;
            else if (n == 5'd18 && s == 5'd9) ns = 6'd0;
            else begin
                ns = {1'b0, s} + 6'd10;
                if (ns >= {1'b0, n}) ns = ns - {1'b0, n};
            end
            p.sec = ns[SW-1:0];
            if (ns == '0) begin
                if (t >= eff)            p.trk = 6'd1;
                else if (t == SKIP_FROM) p.trk = SKIP_TO;
                else                     p.trk = t + 6'd1;
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/isa_fmap.sv =====
// Free-map memory: one row of free bits per track, synchronous read.
// Depends on isa_pkg; per-row valid bits make unwritten rows read as all free.
module isa_fmap import isa_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [ROWW-1:0] rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [ROWW-1:0] wr_data
);

    logic [ROWW-1:0]       mem [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] row_valid_reg;
    logic [ROWW-1:0]       mem_q_reg;
    logic [ROWW-1:0]       mask_q_reg;
    logic                  hit_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg  <= mem[rd_addr];
            hit_q_reg  <= row_valid_reg[rd_addr];
            mask_q_reg <= row_mask(TW'(rd_addr) + TW'(1));
        end
    end

    assign rd_data = hit_q_reg ? mem_q_reg : mask_q_reg;

endmodule

// ===== rtl/isa_glist.sv =====
// Gather list: positions found by the allocation walk, synchronous read.
// Depends on isa_pkg; entries are always written before they are read.
module isa_glist import isa_pkg::*; #(
    parameter int MAX_COUNT = MAX_COUNT_DEF,
    localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [GW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [GW-1:0] wr_data
);

    logic [GW-1:0] mem [MAX_COUNT];
    logic [GW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/interleaved_sector_allocator.sv =====
// Top level of the interleaved sector allocator: config registers, sequencer, result register.
// Depends on isa_pkg, isa_fmap (free map memory) and isa_glist (gather list memory).
//
//  Channel   Handshake             Contents
//  -------   -------------------   ---------------------------------------------------
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data: start track, start sector, tracks
//  in        in_valid/in_ready     kind, track, sector, count
//  out       out_valid/out_ready   status, out_track, out_sector, block_number, is_free, last
//
// One request word is handled at a time. Free and query pass through accept, decode with the
// free-map row read, then the answer with the row write for a free. An allocate walk checks
// each sector visited in S_WCHK, with a free-map row fetch (S_WRD, S_WLD) for each track
// entered, then emits each sector found through S_CRG, S_CRM and S_CWR. A stalled result word
// holds the sequencer where it is. Reset leaves all sectors free through per-row valid bits,
// so no clearing pass is needed.
module interleaved_sector_allocator import isa_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int MAX_COUNT  = MAX_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [TW-1:0] cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    kind,
    input  logic [TW-1:0] track,
    input  logic [SW-1:0] sector,
    input  logic [CW-1:0] count,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [TW-1:0] out_track,
    output logic [SW-1:0] out_sector,
    output logic [BW-1:0] block_number,
    output logic          is_free,
    output logic          last
);

    localparam int FAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int GAW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam logic [TW-1:0] MaxTrk = TW'(MAX_TRACKS);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_COUNT);

    // Configuration registers.
    logic [TW-1:0] start_track_reg;
    logic [SW-1:0] start_sector_reg;
    logic [TW-1:0] num_tracks_reg;
    logic [TW-1:0] eff_tracks;

    // Sequencer state and request/walk registers.
    state_t        state_reg, state_next;
    kind_t         kind_reg, kind_next;
    logic [TW-1:0] trk_reg, trk_next;
    logic [SW-1:0] sec_reg, sec_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] wt_reg, wt_next;
    logic [SW-1:0] ws_reg, ws_next;
    logic [ROWW-1:0] row_reg, row_next;
    logic [CW-1:0] got_reg, got_next;
    logic [CW-1:0] ci_reg, ci_next;
    logic [TW-1:0] gt_reg, gt_next;
    logic [SW-1:0] gs_reg, gs_next;
    status_t       rstat_reg, rstat_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg;
    logic [TW-1:0] out_track_reg;
    logic [SW-1:0] out_sector_reg;
    logic [BW-1:0] block_number_reg;
    logic          is_free_reg;
    logic          last_reg;

    // Emit request from the sequencer.
    logic          emit;
    status_t       e_status;
    logic [TW-1:0] e_track;
    logic [SW-1:0] e_sector;
    logic [BW-1:0] e_block;
    logic          e_free;
    logic          e_last;
    logic          can_emit;

    // Memory ports.
    logic            fm_rd_en, fm_wr_en;
    logic [FAW-1:0]  fm_rd_addr, fm_wr_addr;
    logic [ROWW-1:0] fm_rd_data, fm_wr_data;
    logic            gl_rd_en, gl_wr_en;
    logic [GAW-1:0]  gl_rd_addr, gl_wr_addr;
    logic [GW-1:0]   gl_rd_data, gl_wr_data;

    // Decisions shared by the next-state and output logic.
    logic          req_pos_ok;
    logic          walk_pos_ok;
    logic          walk_hit;
    logic          walk_done;
    pos_t          walk_step;
    logic          walk_back;
    logic          walk_newtrk;
    logic          commit_last;
    logic [TW-1:0] trk_m1, wt_m1, glt_m1, gt_m1;
    logic [CW-1:0] got_inc;

    isa_fmap #(.MAX_TRACKS(MAX_TRACKS)) u_fmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (fm_rd_en),
        .rd_addr (fm_rd_addr),
        .rd_data (fm_rd_data),
        .wr_en   (fm_wr_en),
        .wr_addr (fm_wr_addr),
        .wr_data (fm_wr_data)
    );

    isa_glist #(.MAX_COUNT(MAX_COUNT)) u_glist (
        .clk     (clk),
        .rd_en   (gl_rd_en),
        .rd_addr (gl_rd_addr),
        .rd_data (gl_rd_data),
        .wr_en   (gl_wr_en),
        .wr_addr (gl_wr_addr),
        .wr_data (gl_wr_data)
    );

    // Configuration writes are always taken; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_track_reg  <= 6'd1;
            start_sector_reg <= 5'd0;
            num_tracks_reg   <= 6'd35;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_TRACK:  start_track_reg  <= cfg_data;
                CFG_START_SECTOR: start_sector_reg <= cfg_data[SW-1:0];
                CFG_NUM_TRACKS:   num_tracks_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Track counts above the memory depth act as the depth.
    assign eff_tracks = (num_tracks_reg > MaxTrk) ? MaxTrk : num_tracks_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign can_emit = !out_valid_reg || out_ready;

    assign trk_m1  = trk_reg - 6'd1;
    assign wt_m1   = wt_reg - 6'd1;
    assign glt_m1  = gl_rd_data[GW-1:SW] - 6'd1;
    assign gt_m1   = gt_reg - 6'd1;
    assign got_inc = got_reg + 7'd1;

    assign req_pos_ok  = pos_valid(trk_reg, sec_reg, eff_tracks);
    assign walk_pos_ok = pos_valid(wt_reg, ws_reg, eff_tracks);
    assign walk_hit    = row_reg[ws_reg];
    assign walk_done   = walk_hit && (got_inc == cnt_reg);
    assign walk_step   = step_pos(wt_reg, ws_reg, eff_tracks);
    assign walk_back   = (walk_step.trk == start_track_reg) &&
                         (walk_step.sec == start_sector_reg);
    assign walk_newtrk = (walk_step.trk != wt_reg);
    assign commit_last = ((ci_reg + 7'd1) == got_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (kind_reg)
                    KIND_FREE, KIND_QUERY:
                    begin
                        state_next = req_pos_ok ? S_QDONE : S_RESP;
                    end
                    KIND_ALLOC:
                    begin
                        if (cnt_reg == '0 || cnt_reg > MaxCnt)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_WRD;
                        end
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_QDONE:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRD:   state_next = walk_pos_ok ? S_WLD : S_RESP;
            S_WLD:   state_next = S_WCHK;
            S_WCHK:
            begin
                if (walk_done)
                begin
                    state_next = S_CRG;
                end
                else if (walk_back)
                begin
                    state_next = S_RESP;
                end
                else if (walk_newtrk)
                begin
                    state_next = S_WRD;
                end
            end
            S_CRG:   state_next = S_CRM;
            S_CRM:   state_next = S_CWR;
            S_CWR:
            begin
                if (can_emit)
                begin
                    state_next = commit_last ? S_IDLE : S_CRG;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory and emit controls.
    always_comb
    begin
        kind_next  = kind_reg;
        trk_next   = trk_reg;
        sec_next   = sec_reg;
        cnt_next   = cnt_reg;
        wt_next    = wt_reg;
        ws_next    = ws_reg;
        row_next   = row_reg;
        got_next   = got_reg;
        ci_next    = ci_reg;
        gt_next    = gt_reg;
        gs_next    = gs_reg;
        rstat_next = rstat_reg;

        fm_rd_en   = 1'b0;
        fm_rd_addr = trk_m1[FAW-1:0];
        fm_wr_en   = 1'b0;
        fm_wr_addr = trk_m1[FAW-1:0];
        fm_wr_data = fm_rd_data | (ROWW'(1) << sec_reg);
        gl_rd_en   = 1'b0;
        gl_rd_addr = ci_reg[GAW-1:0];
        gl_wr_en   = 1'b0;
        gl_wr_addr = got_reg[GAW-1:0];
        gl_wr_data = {wt_reg, ws_reg};

        emit     = 1'b0;
        e_status = rstat_reg;
        e_track  = '0;
        e_sector = '0;
        e_block  = '0;
        e_free   = 1'b0;
        e_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind_t'(kind);
                    trk_next  = track;
                    sec_next  = sector;
                    cnt_next  = count;
                end
            end
            S_DECODE:
            begin
                case (kind_reg)
                    KIND_FREE, KIND_QUERY:
                    begin
                        rstat_next = ST_INVALID;
                        fm_rd_en   = req_pos_ok;
                    end
                    KIND_ALLOC:
                    begin
                        rstat_next = (cnt_reg == '0) ? ST_OK : ST_NOSPACE;
                        wt_next    = start_track_reg;
                        ws_next    = start_sector_reg;
                        got_next   = '0;
                    end
                    default: rstat_next = ST_INVALID;
                endcase
            end
            S_RESP:
            begin
                emit = can_emit;
            end
            S_QDONE:
            begin
                emit     = can_emit;
                e_status = ST_OK;
                if (kind_reg == KIND_QUERY)
                begin
                    e_free = fm_rd_data[sec_reg];
                end
                else
                begin
                    fm_wr_en = can_emit;
                end
            end
            S_WRD:
            begin
                // A walk that reaches an invalid position fails.
                rstat_next = ST_NOSPACE;
                fm_rd_en   = walk_pos_ok;
                fm_rd_addr = wt_m1[FAW-1:0];
            end
            S_WLD:
            begin
                row_next = fm_rd_data;
            end
            S_WCHK:
            begin
                if (walk_hit)
                begin
                    gl_wr_en = 1'b1;
                    got_next = got_inc;
                end
                if (walk_done)
                begin
                    ci_next = '0;
                end
                else
                begin
                    wt_next = walk_step.trk;
                    ws_next = walk_step.sec;
                end
            end
            S_CRG:
            begin
                gl_rd_en = 1'b1;
            end
            S_CRM:
            begin
                gt_next    = gl_rd_data[GW-1:SW];
                gs_next    = gl_rd_data[SW-1:0];
                fm_rd_en   = 1'b1;
                fm_rd_addr = glt_m1[FAW-1:0];
            end
            S_CWR:
            begin
                // The row write lands before the next row read, so no forwarding is needed.
                emit       = can_emit;
                e_status   = ST_OK;
                e_track    = gt_reg;
                e_sector   = gs_reg;
                e_block    = base_of(gt_reg) + BW'(gs_reg);
                e_last     = commit_last;
                fm_wr_en   = can_emit;
                fm_wr_addr = gt_m1[FAW-1:0];
                fm_wr_data = fm_rd_data & ~(ROWW'(1) << gs_reg);
                if (can_emit)
                begin
                    ci_next = ci_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        trk_reg   <= trk_next;
        sec_reg   <= sec_next;
        cnt_reg   <= cnt_next;
        wt_reg    <= wt_next;
        ws_reg    <= ws_next;
        row_reg   <= row_next;
        got_reg   <= got_next;
        ci_reg    <= ci_next;
        gt_reg    <= gt_next;
        gs_reg    <= gs_next;
        rstat_reg <= rstat_next;
        if (emit)
        begin
            status_reg       <= e_status;
            out_track_reg    <= e_track;
            out_sector_reg   <= e_sector;
            block_number_reg <= e_block;
            is_free_reg      <= e_free;
            last_reg         <= e_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_track    = out_track_reg;
    assign out_sector   = out_sector_reg;
    assign block_number = block_number_reg;
    assign is_free      = is_free_reg;
    assign last         = last_reg;

endmodule

// ===== tb/sv/interleaved_sector_allocator_tb.sv =====
// Self-checking testbench for interleaved_sector_allocator: directed and random requests,
// with a built-in free-map predictor. Depends on isa_pkg and the allocator RTL only.
module interleaved_sector_allocator_tb import isa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int CHUNK_ITEMS    = 85;
    localparam int HOLD_CYCLES    = 500;

    typedef struct packed {
        logic [1:0]    kind;
        logic [TW-1:0] track;
        logic [SW-1:0] sector;
        logic [CW-1:0] count;
    } request_t;

    typedef struct packed {
        status_t       status;
        logic [TW-1:0] trk;
        logic [SW-1:0] sec;
        logic [BW-1:0] blk;
        logic          free_bit;
        logic          lst;
    } sector_word_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [TW-1:0] cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [1:0]    kind = '0;
    logic [TW-1:0] track = '0;
    logic [SW-1:0] sector = '0;
    logic [CW-1:0] count = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [1:0]    status;
    logic [TW-1:0] out_track;
    logic [SW-1:0] out_sector;
    logic [BW-1:0] block_number;
    logic          is_free;
    logic          last;

    interleaved_sector_allocator dut (.*);

    always #1 clk = ~clk;

    // Predictor state: the free map, the three registers, and the sectors handed out so far
    // (so that random frees mostly return sectors that are really in use).
    logic [ROWW-1:0] free_rows [1:MAX_TRACKS_DEF];
    logic [TW-1:0]   walk_start_track;
    logic [SW-1:0]   walk_start_sector;
    logic [TW-1:0]   track_count_reg;
    logic [GW-1:0]   handed_out [$];

    request_t     pending_requests [$];
    sector_word_t expected_words [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int requests_taken = 0;
    int words_checked = 0;
    int allocs_granted = 0;
    int allocs_refused = 0;
    int quiet_cycles = 0;

    function automatic int sectors_in(int t);
        if (t <= 17) return 21;
        if (t <= 24) return 19;
        if (t <= 30) return 18;
        return 17;
    endfunction

    function automatic int first_block(int t);
        int acc;
        acc = 0;
        for (int k = 1; k < t; k++) acc += sectors_in(k);
        return acc;
    endfunction

    function automatic int usable_tracks();
        return track_count_reg > MAX_TRACKS_DEF ? MAX_TRACKS_DEF : int'(track_count_reg);
    endfunction

    function automatic bit on_disk(int t, int s);
        return t >= 1 && t <= usable_tracks() && s < sectors_in(t);
    endfunction

    // Advances one position along the interleave; an invalid position or the end of the
    // directory track leads to track 0, which stops the walk.
    function automatic void interleave_next(inout int t, inout int s);
        int n;
        if (!on_disk(t, s)) begin
            t = 0;
            s = 0;
            return;
        end
        if (t == DIR_TRACK) begin
            s = (s + 3) % 19;
            if (s == 0) t = 0;
            return;
        end
        n = sectors_in(t);
        if (n == 18 && s == 8) s = 1;
        else if (n == 18 && s == 9) s = 0;
        else s = (s + 10) % n;
        if (s == 0) t = (t >= usable_tracks()) ? 1 : (t == SKIP_FROM ? SKIP_TO : t + 1);
    endfunction

    function automatic void expect_word(status_t st, int t, int s, int b, bit fr, bit lst);
        sector_word_t w;
        w.status = st;
        w.trk = TW'(t);
        w.sec = SW'(s);
        w.blk = BW'(b);
        w.free_bit = fr;
        w.lst = lst;
        expected_words = {expected_words, w};
    endfunction

    function automatic void predict_request(request_t r);
        int t, s, got, steps;
        bit ok;
        int gath_t [MAX_COUNT_DEF];
        int gath_s [MAX_COUNT_DEF];
        got = 0;
        ok = 0;
        if (r.kind == KIND_FREE || r.kind == KIND_QUERY) begin
            if (!on_disk(r.track, r.sector)) begin
                expect_word(ST_INVALID, 0, 0, 0, 0, 1);
            end else if (r.kind == KIND_FREE) begin
                free_rows[r.track][r.sector] = 1'b1;
                expect_word(ST_OK, 0, 0, 0, 0, 1);
            end else begin
                expect_word(ST_OK, 0, 0, 0, free_rows[r.track][r.sector], 1);
            end
            return;
        end
        if (r.kind == KIND_RSVD) begin
            expect_word(ST_INVALID, 0, 0, 0, 0, 1);
            return;
        end
        if (r.count == 0) begin
            expect_word(ST_OK, 0, 0, 0, 0, 1);
            return;
        end
        if (r.count > MAX_COUNT_DEF) begin
            expect_word(ST_NOSPACE, 0, 0, 0, 0, 1);
            allocs_refused++;
            return;
        end
        t = walk_start_track;
        s = walk_start_sector;
        for (steps = 0; steps <= MAX_TRACKS_DEF * 21; steps++) begin
            if (!on_disk(t, s)) break;
            if (free_rows[t][s]) begin
                gath_t[got] = t;
                gath_s[got] = s;
                got++;
                if (got == r.count) begin
                    ok = 1;
                    break;
                end
            end
            interleave_next(t, s);
            if (t == walk_start_track && s == walk_start_sector) break;
        end
        if (!ok) begin
            expect_word(ST_NOSPACE, 0, 0, 0, 0, 1);
            allocs_refused++;
            return;
        end
        allocs_granted++;
        for (int k = 0; k < got; k++) begin
            free_rows[gath_t[k]][gath_s[k]] = 1'b0;
            handed_out = {handed_out, {gath_t[k][TW-1:0], gath_s[k][SW-1:0]}};
            expect_word(ST_OK, gath_t[k], gath_s[k], first_block(gath_t[k]) + gath_s[k], 0,
                        k == got - 1);
        end
    endfunction

    // Driver: offers the next pending word, holds it until accepted, and hands each
    // accepted word to the predictor.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_ready) begin
            in_valid <= 1'b1;
        end else begin
            if (in_valid) begin
                predict_request('{kind, track, sector, count});
                requests_taken++;
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid <= 1'b1;
                kind <= r.kind;
                track <= r.track;
                sector <= r.sector;
                count <= r.count;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure plus one long hold-off early in the run, so the
    // allocator fills up and stops taking requests.
    int hold_left = 0;
    bit hold_done = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                sector_word_t want;
                words_checked++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d track %0d sector %0d",
                             $time, status, out_track, out_sector);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 status);
                        error_count++;
                    end
                    if (out_track !== want.trk) begin
                        $display("%0t: out_track expected %0d actual %0d", $time, want.trk,
                                 out_track);
                        error_count++;
                    end
                    if (out_sector !== want.sec) begin
                        $display("%0t: out_sector expected %0d actual %0d", $time, want.sec,
                                 out_sector);
                        error_count++;
                    end
                    if (block_number !== want.blk) begin
                        $display("%0t: block_number expected %0d actual %0d", $time, want.blk,
                                 block_number);
                        error_count++;
                    end
                    if (is_free !== want.free_bit) begin
                        $display("%0t: is_free expected %0d actual %0d", $time, want.free_bit,
                                 is_free);
                        error_count++;
                    end
                    if (last !== want.lst) begin
                        $display("%0t: last expected %0d actual %0d", $time, want.lst, last);
                        error_count++;
                    end
                end
            end
            if (!hold_done && words_checked >= 50) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= $urandom_range(99) >= receiver_stall_pct;
            end
        end
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [TW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_TRACK) walk_start_track = value;
        else if (idx == CFG_START_SECTOR) walk_start_sector = value[SW-1:0];
        else if (idx == CFG_NUM_TRACKS) track_count_reg = value;
    endtask

    task automatic configure(int st, int ss, int nt);
        write_register(CFG_START_TRACK, TW'(st));
        write_register(CFG_START_SECTOR, TW'(ss));
        write_register(CFG_NUM_TRACKS, TW'(nt));
    endtask

    // Waits until every queued word has been taken and every result has come back.
    task automatic drain();
        do @(negedge clk);
        while (pending_requests.size() > 0 || in_valid || expected_words.size() > 0);
        repeat (10) @(negedge clk);
    endtask

    function automatic void queue_request(int k, int t, int s, int c);
        request_t r;
        r.kind = 2'(k);
        r.track = TW'(t);
        r.sector = SW'(s);
        r.count = CW'(c);
        pending_requests = {pending_requests, r};
    endfunction

    // Random traffic: mostly well-formed allocations and frees of sectors in use, with
    // queries, odd counts and malformed positions mixed in.
    function automatic void queue_random(int n);
        int pick, t, s, idx;
        logic [GW-1:0] p;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            t = $urandom_range(usable_tracks(), 1);
            s = $urandom_range(sectors_in(t) - 1);
            if (pick < 45) begin
                if ($urandom_range(99) < 80) queue_request(KIND_ALLOC, t, s, $urandom_range(6, 1));
                else if ($urandom_range(99) < 75) queue_request(KIND_ALLOC, t, s,
                                                                $urandom_range(64, 7));
                else queue_request(KIND_ALLOC, t, s, $urandom_range(1) ? 0 : $urandom_range(127, 65));
            end else if (pick < 80) begin
                if (handed_out.size() > 0 && $urandom_range(99) < 70) begin
                    idx = $urandom_range(handed_out.size() - 1);
                    p = handed_out[idx];
                    handed_out.delete(idx);
                    queue_request(KIND_FREE, p[GW-1:SW], p[SW-1:0], $urandom_range(127));
                end else begin
                    queue_request(KIND_FREE, t, s, $urandom_range(127));
                end
            end else if (pick < 95) begin
                queue_request(KIND_QUERY, t, s, $urandom_range(127));
            end else begin
                queue_request($urandom_range(3), $urandom_range(63), $urandom_range(31),
                              $urandom_range(127));
            end
        end
    endfunction

    initial begin
        for (int t = 1; t <= MAX_TRACKS_DEF; t++)
            free_rows[t] = (ROWW'(1) << sectors_in(t)) - ROWW'(1);
        walk_start_track = 1;
        walk_start_sector = 0;
        track_count_reg = 35;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings: boundaries of every field and each corner case.
        sender_idle_pct = 12;
        receiver_stall_pct = 46;
        queue_request(KIND_QUERY, 1, 0, 0);
        queue_request(KIND_ALLOC, 0, 0, 1);
        queue_request(KIND_QUERY, 1, 0, 0);
        queue_request(KIND_ALLOC, 63, 31, 64);
        queue_request(KIND_FREE, 1, 0, 127);
        queue_request(KIND_QUERY, 17, 20, 0);
        queue_request(KIND_FREE, 0, 0, 0);
        queue_request(KIND_FREE, 63, 31, 0);
        queue_request(KIND_QUERY, 1, 21, 0);
        queue_request(KIND_QUERY, 18, 19, 0);
        queue_request(KIND_QUERY, 36, 0, 0);
        queue_request(KIND_QUERY, 35, 16, 0);
        queue_request(KIND_RSVD, 5, 5, 5);
        queue_request(KIND_ALLOC, 1, 1, 0);
        queue_request(KIND_ALLOC, 1, 1, 65);
        queue_request(KIND_ALLOC, 1, 1, 127);
        drain();

        // Directory track: the walk ends when the sector wraps, so a big request fails.
        configure(18, 0, 35);
        queue_request(KIND_ALLOC, 0, 0, 20);
        queue_request(KIND_ALLOC, 0, 0, 19);
        queue_request(KIND_ALLOC, 0, 0, 1);
        queue_random(CHUNK_ITEMS - 3);
        drain();

        // Last track of the largest disk: the walk wraps to track 1.
        configure(42, 16, 42);
        queue_request(KIND_ALLOC, 0, 0, 64);
        queue_request(KIND_QUERY, 42, 16, 0);
        sender_idle_pct = 46;
        receiver_stall_pct = 12;
        queue_random(CHUNK_ITEMS / 2);
        drain();
        // The sender pauses here until everything has come back, then carries on.
        queue_random(CHUNK_ITEMS / 2);
        drain();

        // Start at the end of track 17, with a count register between the extremes.
        configure(17, 20, 40);
        queue_random(CHUNK_ITEMS);
        drain();

        // Invalid start and oversized count register: every allocation of one or more sectors is refused.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        configure(0, 31, 63);
        queue_random(20);
        drain();

        // Fewer tracks than the usual range, then back to reset settings.
        configure(31, 5, 34);
        queue_random(CHUNK_ITEMS);
        drain();
        configure(1, 0, 35);
        queue_random(CHUNK_ITEMS);
        drain();
        repeat (20) @(negedge clk);

        $display("Ran %0d requests and checked %0d result words over seven register settings.",
                 requests_taken, words_checked);
        $display("Allocations granted %0d, refused for lack of space %0d.", allocs_granted,
                 allocs_refused);
        if (error_count == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== interleaved_sector_allocator.f =====
rtl/isa_pkg.sv
rtl/isa_fmap.sv
rtl/isa_glist.sv
rtl/interleaved_sector_allocator.sv
tb/sv/interleaved_sector_allocator_tb.sv
